[sv/fbc_pkg.sv]
// Shared types and constants for the frustum box cull block.
// Used by the plane cell, the top level and the testbench; no dependencies.
package fbc_pkg;

    // Six clip planes, one cell each
    localparam int C_NUM_PLANES = 6;
    // Sections per chunk; a level at or above this counts as absent
    localparam int C_SECTIONS   = 16;

    // Config register indexes (planes take indexes 0 to 5)
    localparam logic [2:0] C_IDX_BOX_SIZE = 3'd6;
    localparam logic [8:0] C_BOX_SIZE_RST = 9'd16;

    // Box corners; x and z reach one half-size past a 16-bit center
    typedef struct packed {
        logic signed [16:0] x0;
        logic signed [16:0] x1;
        logic signed [16:0] z0;
        logic signed [16:0] z1;
        logic signed [13:0] y0;
        logic signed [13:0] y1;
    } t_box;

    // Per-word control that travels with the box
    typedef struct packed {
        logic valid;
        logic vis;
        logic last;
    } t_tag;

endpackage

[sv/fbc_cell.sv]
// One plane cell of the culling chain: picks the far corner, forms the
// signed distance over two registered steps and clears visibility on a miss.
// Depends on fbc_pkg.
module fbc_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [63:0]   i_plane,
    input  fbc_pkg::t_box i_box,
    input  fbc_pkg::t_tag i_tag,
    output fbc_pkg::t_box o_box,
    output fbc_pkg::t_tag o_tag
);
    import fbc_pkg::*;

    logic signed [15:0] nx, ny, nz;
    logic signed [16:0] sel_x, sel_z;
    logic signed [13:0] sel_y;
    logic signed [35:0] n_dist;

    t_box r_box_a, r_box_b;
    t_tag r_tag_a, r_tag_b;
    logic signed [32:0] r_px, r_pz;
    logic signed [29:0] r_py;
    logic signed [15:0] r_d;

    // Unpack the plane and pick the corner farthest along the normal
    always_comb begin
        nx    = i_plane[15:0];
        ny    = i_plane[31:16];
        nz    = i_plane[47:32];
        sel_x = nx[15] ? i_box.x0 : i_box.x1;
        sel_y = ny[15] ? i_box.y0 : i_box.y1;
        sel_z = nz[15] ? i_box.z0 : i_box.z1;
    end

    // Sum the products with the offset scaled to Q.14
    always_comb begin
        n_dist = 36'(r_px) + 36'(r_py) + 36'(r_pz)
               + {{6{r_d[15]}}, r_d, 14'b0};
    end

    // Control: advance valid with the chain, drop visibility on a negative distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
        end else if (i_en) begin
            r_tag_a       <= i_tag;
            r_tag_b.valid <= r_tag_a.valid;
            r_tag_b.last  <= r_tag_a.last;
            r_tag_b.vis   <= r_tag_a.vis & ~n_dist[35];
        end
    end

    // Payload: products in the first step, box handed on
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= nx * sel_x;
            r_py    <= ny * sel_y;
            r_pz    <= nz * sel_z;
            r_d     <= i_plane[63:48];
            r_box_a <= i_box;
            r_box_b <= r_box_a;
        end
    end

    assign o_box = r_box_b;
    assign o_tag = r_tag_b;

endmodule

[sv/frustum_box_cull.sv]
// Frustum culling of chunk sections against six planes, one section per cycle while not stalled.
// The last section of a chunk passes box setup (loaded at acceptance), then six plane
// cells, then the output word that carries the chunk flag.
// Throughput: one section per cycle; the chain halts only while the output
// skid word is full. Reset clears planes to 0, box size to 16 and the flag.
module frustum_box_cull (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Section input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_center_x,
    input  logic signed [15:0] i_center_z,
    input  logic [3:0]         i_level,
    input  logic               i_present,
    input  logic               i_last_section,
    // Chunk result
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_chunk_visible,
    // Config writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    import fbc_pkg::*;

    logic [63:0] r_plane [C_NUM_PLANES];
    logic [8:0]  r_box_size;
    logic        r_acc;
    logic        r_out_valid, r_out_vis;
    logic        r_skid_valid, r_skid_vis;
    t_box        r_box0;
    t_tag        r_tag0;

    t_box        w_box [C_NUM_PLANES+1];
    t_tag        w_tag [C_NUM_PLANES+1];

    logic        en;
    logic        counted;
    logic [8:0]  size;
    logic [7:0]  half;
    logic [12:0] y0_u, y1_u;
    logic        res_valid, res_vis, n_acc;

    // Config: always ready, ignore indexes past the list
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < C_NUM_PLANES; i++) r_plane[i] <= '0;
            r_box_size <= C_BOX_SIZE_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == C_IDX_BOX_SIZE) begin
                r_box_size <= i_cfg_data[8:0];
            end else if (32'(i_cfg_index) < C_NUM_PLANES) begin
                r_plane[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    // Halt the whole chain while the skid word is full
    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    // Box setup: odd size bit dropped, y span from the level
    always_comb begin
        size    = {r_box_size[8:1], 1'b0};
        half    = r_box_size[8:1];
        y0_u    = 13'(i_level) * 13'(size);
        y1_u    = y0_u + 13'(size);
        counted = i_present && (32'(i_level) < C_SECTIONS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0 <= '0;
        end else if (en) begin
            r_tag0.valid <= i_in_valid;
            r_tag0.vis   <= counted;
            r_tag0.last  <= i_last_section;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_box0.x0 <= 17'(i_center_x) - 17'(half);
            r_box0.x1 <= 17'(i_center_x) + 17'(half);
            r_box0.z0 <= 17'(i_center_z) - 17'(half);
            r_box0.z1 <= 17'(i_center_z) + 17'(half);
            r_box0.y0 <= {1'b0, y0_u};
            r_box0.y1 <= {1'b0, y1_u};
        end
    end

    assign w_box[0] = r_box0;
    assign w_tag[0] = r_tag0;

    // Plane cells in a row
    for (genvar g = 0; g < C_NUM_PLANES; g++) begin : g_cell
        fbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_plane (r_plane[g]),
            .i_box   (w_box[g]),
            .i_tag   (w_tag[g]),
            .o_box   (w_box[g+1]),
            .o_tag   (w_tag[g+1])
        );
    end

    // Collect visibility over the chunk; emit on the last section
    always_comb begin
        n_acc     = r_acc | (w_tag[C_NUM_PLANES].valid & w_tag[C_NUM_PLANES].vis);
        res_valid = en && w_tag[C_NUM_PLANES].valid && w_tag[C_NUM_PLANES].last;
        res_vis   = n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 1'b0;
        end else if (en && w_tag[C_NUM_PLANES].valid) begin
            r_acc <= w_tag[C_NUM_PLANES].last ? 1'b0 : n_acc;
        end
    end

    // Output word with a skid word behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out_vis <= r_skid_valid ? r_skid_vis : res_vis;
        end else if (res_valid) begin
            r_skid_vis <= res_vis;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chunk_visible = r_out_vis;

endmodule

[sv/fbc_checker.sv]
// Port-level checks for frustum_box_cull, attached by bind.
// Depends on the top level's ports only.
module fbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_chunk_visible
);

    // Held result keeps its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_chunk_visible))
        else $error("stalled result changed");

    // Reset empties the output and the skid word
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output not empty after reset");

    // Input stalls only after a result was held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // A taken result drains the skid word at once
    a_stall_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !i_out_stall |=> !o_in_stall)
        else $error("input stall outlived the output stall");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_chunk_visible (o_chunk_visible)
);

[test/frustum_box_cull_tb.sv]
// Self-checking testbench for frustum_box_cull: section boxes against six planes.
// Depends on fbc_pkg and the frustum_box_cull top level; a local predictor
// shadows the plane and box size registers and checks every chunk word.
`timescale 1ns / 1ps

module frustum_box_cull_tb;
    import fbc_pkg::*;

    localparam int     PHASE_ITEMS   = 90;
    localparam int     RAND_PHASES   = 8;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     SPAN          = 500;
    localparam longint Q_ONE         = 16384;

    // Plane register indexes and a spare index; box size comes from the package
    localparam logic [2:0] REG_LEFT   = 3'd0;
    localparam logic [2:0] REG_FAR    = 3'd5;
    localparam logic [2:0] REG_SPARE  = 3'd7;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    logic               i_clk;
    logic               i_rst_n         = 1'b0;
    logic               i_in_valid      = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_center_x      = '0;
    logic signed [15:0] i_center_z      = '0;
    logic [3:0]         i_level         = '0;
    logic               i_present       = 1'b0;
    logic               i_last_section  = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall     = 1'b0;
    logic               o_chunk_visible;
    logic               i_cfg_valid     = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index     = '0;
    logic [63:0]        i_cfg_data      = '0;

    // Register shadow and running chunk flag
    logic [63:0] plane_shadow [C_NUM_PLANES] = '{default: '0};
    logic [8:0]  size_shadow = C_BOX_SIZE_RST;
    logic        chunk_seen_visible = 1'b0;
    logic        chunk_flag_q [$];
    logic        flag_want;

    // Staging for a full register load
    logic [63:0] next_planes [C_NUM_PLANES];
    logic [8:0]  next_size;

    int       fail_count     = 0;
    int       sections_taken = 0;
    int       chunks_checked = 0;
    int       chunks_visible = 0;
    int       cfg_writes     = 0;
    int       burst_left     = 0;
    int       rx_tick        = 0;
    bit       gaps_on        = 1'b0;
    bit       hold_on        = 1'b0;
    rx_mode_t rx_mode        = RX_OPEN;
    event     hold_ev;

    frustum_box_cull dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_center_x      (i_center_x),
        .i_center_z      (i_center_z),
        .i_level         (i_level),
        .i_present       (i_present),
        .i_last_section  (i_last_section),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_chunk_visible (o_chunk_visible),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d chunk words still expected", chunk_flag_q.size());
        $display("TEST FAILED");
        $finish;
    end

    // Box passes when every plane keeps its farthest positive corner
    function automatic logic box_passes(input logic signed [15:0] cx,
                                        input logic signed [15:0] cz,
                                        input logic [3:0] lvl);
        longint sz, half, x0, x1, y0, y1, z0, z1;
        longint nx, ny, nz, ofs, px, py, pz, signed_dist;
        logic   pass;
        sz   = longint'(size_shadow & 9'h1FE);
        half = sz / 2;
        x0   = longint'(cx) - half;
        x1   = longint'(cx) + half;
        z0   = longint'(cz) - half;
        z1   = longint'(cz) + half;
        y0   = longint'(lvl) * sz;
        y1   = y0 + sz;
        pass = 1'b1;
        for (int p = 0; p < C_NUM_PLANES; p++) begin
            nx   = longint'($signed(plane_shadow[p][15:0]));
            ny   = longint'($signed(plane_shadow[p][31:16]));
            nz   = longint'($signed(plane_shadow[p][47:32]));
            ofs  = longint'($signed(plane_shadow[p][63:48]));
            px   = (nx >= 0) ? x1 : x0;
            py   = (ny >= 0) ? y1 : y0;
            pz   = (nz >= 0) ? z1 : z0;
            signed_dist = nx * px + ny * py + nz * pz + ofs * Q_ONE;
            if (signed_dist < 0) pass = 1'b0;
        end
        return pass;
    endfunction

    function automatic logic [63:0] pack_plane(input int nx, input int ny,
                                               input int nz, input int ofs);
        return {16'(ofs), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    // Mostly near the frustum, sometimes anywhere in the 16-bit range
    function automatic logic signed [15:0] rand_coord();
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
    endfunction

    // Score result words, track register writes, predict on accepted sections
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (chunk_flag_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected chunk word, chunk_visible=%0b",
                                 $realtime, o_chunk_visible);
                end else begin
                    flag_want = chunk_flag_q.pop_front();
                    chunks_checked++;
                    if (o_chunk_visible !== flag_want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: chunk %0d chunk_visible expected %0b got %0b",
                                     $realtime, chunks_checked, flag_want,
                                     o_chunk_visible);
                    end else if (flag_want) begin
                        chunks_visible++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                if (i_cfg_index < C_NUM_PLANES)
                    plane_shadow[i_cfg_index] = i_cfg_data;
                else if (i_cfg_index == C_IDX_BOX_SIZE)
                    size_shadow = i_cfg_data[8:0];
            end
            if (i_in_valid && !o_in_stall) begin
                sections_taken++;
                if (i_present && i_level < C_SECTIONS &&
                    box_passes(i_center_x, i_center_z, i_level))
                    chunk_seen_visible = 1'b1;
                if (i_last_section) begin
                    chunk_flag_q = {chunk_flag_q, chunk_seen_visible};
                    chunk_seen_visible = 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always begin
        @(hold_ev);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_on = 1'b0;
    end

    // Receiver stall pattern
    always @(negedge i_clk) begin
        rx_tick++;
        case (rx_mode)
            RX_RANDOM:   i_out_stall = hold_on | ($urandom_range(0, 99) < 35);
            RX_PERIODIC: i_out_stall = hold_on | ((rx_tick % 11) < 4);
            default:     i_out_stall = hold_on;
        endcase
    end

    task automatic idle_input(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    // Offer one section word, hold it until taken, then maybe pause the burst
    task automatic offer_section(input logic signed [15:0] cx,
                                 input logic signed [15:0] cz,
                                 input logic [3:0] lvl,
                                 input logic pres, input logic lst);
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_center_x     = cx;
        i_center_z     = cz;
        i_level        = lvl;
        i_present      = pres;
        i_last_section = lst;
        do @(posedge i_clk); while (o_in_stall);
        if (gaps_on) begin
            if (burst_left == 0) begin
                idle_input($urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Drop valid, wait for every chunk word, then let the pipeline empty
    task automatic settle();
        idle_input(1);
        while (chunk_flag_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_config();
        settle();
        for (int p = 0; p < C_NUM_PLANES; p++)
            cfg_write(3'(p), next_planes[p]);
        cfg_write(C_IDX_BOX_SIZE, 64'(next_size));
    endtask

    // Tilted box frustum around the origin
    task automatic pick_frustum();
        int comp [3];
        int axis;
        int ofs;
        for (int p = 0; p < C_NUM_PLANES; p++) begin
            axis = p / 2;
            for (int a = 0; a < 3; a++)
                comp[a] = int'($urandom_range(0, 4000)) - 2000;
            comp[axis] = ((p % 2 == 0) ? 1 : -1) * int'($urandom_range(8192, 16384));
            if (axis == 1)
                ofs = (p % 2 == 0) ? -int'($urandom_range(0, 150))
                                   : int'($urandom_range(50, 3000));
            else
                ofs = int'($urandom_range(SPAN / 4, SPAN));
            next_planes[p] = pack_plane(comp[0], comp[1], comp[2], ofs);
        end
    endtask

    // One column of sections; sometimes the closing mark is left off
    task automatic send_random_chunk(output int n);
        logic signed [15:0] cx, cz;
        int  first;
        bit  broken;
        n      = $urandom_range(1, C_SECTIONS);
        first  = $urandom_range(0, C_SECTIONS - n);
        cx     = rand_coord();
        cz     = rand_coord();
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n; k++)
            offer_section(cx, cz, 4'(first + k), $urandom_range(0, 9) != 0,
                          (k == n - 1) && !broken);
    endtask

    // Planes all zero after reset: every present section is visible
    task automatic test_reset_defaults();
        rx_mode = RX_RANDOM;
        offer_section(16'sd0, 16'sd0, 4'd0, 1'b1, 1'b0);
        offer_section(16'sd32767, -16'sd32768, 4'd15, 1'b0, 1'b1);
        offer_section(-16'sd32768, 16'sd32767, 4'd15, 1'b0, 1'b1);
        offer_section(16'sd100, -16'sd100, 4'd7, 1'b1, 1'b1);
    endtask

    // Left plane at x = -50; each size straddles it, odd and zero sizes too
    task automatic test_box_sizes();
        logic [8:0] sizes [5] = '{9'd0, 9'd2, 9'd17, 9'd256, 9'd511};
        int half;
        rx_mode = RX_PERIODIC;
        settle();
        cfg_write(REG_LEFT, pack_plane(16384, 0, 0, 50));
        foreach (sizes[s]) begin
            settle();
            cfg_write(C_IDX_BOX_SIZE, 64'(sizes[s]));
            half = int'(sizes[s] & 9'h1FE) / 2;
            offer_section(16'(-50 - half), 16'sd3, 4'd2, 1'b1, 1'b1);
            offer_section(16'(-51 - half), 16'sd3, 4'd2, 1'b1, 1'b1);
        end
    endtask

    // A write past the register list must leave everything as it was
    task automatic test_ignored_index();
        int half;
        settle();
        cfg_write(REG_SPARE, {$urandom, $urandom});
        half = int'(size_shadow & 9'h1FE) / 2;
        offer_section(16'(-50 - half), -16'sd9, 4'd0, 1'b1, 1'b1);
        offer_section(16'(-51 - half), -16'sd9, 4'd0, 1'b1, 1'b1);
    endtask

    // Extreme normal and offset codes at the corners of the center range
    task automatic test_plane_extremes();
        rx_mode = RX_OPEN;
        settle();
        cfg_write(REG_LEFT, pack_plane(-32768, 32767, -32768, 32767));
        cfg_write(C_IDX_BOX_SIZE, 64'd2);
        offer_section(16'sd32767, 16'sd32767, 4'd0, 1'b1, 1'b1);
        offer_section(-16'sd32768, -16'sd32768, 4'd15, 1'b1, 1'b1);
        offer_section(16'sd32767, -16'sd32768, 4'd15, 1'b1, 1'b1);
        offer_section(-16'sd32768, 16'sd32767, 4'd0, 1'b1, 1'b1);
        settle();
        cfg_write(REG_FAR, pack_plane(0, 0, 0, -32768));
        offer_section(16'sd0, 16'sd0, 4'd8, 1'b1, 1'b1);
    endtask

    task automatic test_random_chunks();
        int sent;
        int n;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase % 4 == 3) begin
                foreach (next_planes[p]) next_planes[p] = {$urandom, $urandom};
            end else begin
                pick_frustum();
            end
            if ($urandom_range(0, 3) == 0) next_size = 9'($urandom);
            else next_size = 9'($urandom_range(2, 40));
            load_config();
            rx_mode = rx_mode_t'(phase % 3);
            gaps_on = (phase % 4 != 1);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    offer_section(16'($urandom), 16'($urandom), 4'($urandom),
                                  1'($urandom), 1'($urandom));
                    sent++;
                end else begin
                    send_random_chunk(n);
                    sent += n;
                end
            end
        end
    endtask

    // Hold the receiver off while single-section chunks keep coming
    task automatic test_backpressure();
        settle();
        pick_frustum();
        next_size = 9'd16;
        load_config();
        rx_mode = RX_OPEN;
        gaps_on = 1'b0;
        -> hold_ev;
        repeat (60)
            offer_section(rand_coord(), rand_coord(), 4'($urandom),
                          $urandom_range(0, 7) != 0, 1'b1);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_box_sizes();
        test_ignored_index();
        test_plane_extremes();
        test_random_chunks();
        test_backpressure();
        settle();
        $display("covered %0d sections, %0d chunk words (%0d visible), %0d register writes",
                 sections_taken, chunks_checked, chunks_visible, cfg_writes);
        $display("random frustums and raw planes, box sizes 0..511, stalls and a long hold-off");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d failures", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/fbc_pkg.sv
sv/fbc_cell.sv
sv/frustum_box_cull.sv
sv/fbc_checker.sv
test/frustum_box_cull_tb.sv
